>>> rtl/cdgs_pkg.sv
// Shared constants, codes and types of the coverage disc grid stamp.
package cdgs_pkg;

	// Grid and disc limits (MAX_SIDE is a power of two: cell address is {row, col})
	localparam int MAX_SIDE    = 256;
	localparam int MAX_RADIUS  = 63;
	localparam int SIDE_W      = $clog2(MAX_SIDE);
	localparam int ADDR_W      = 2 * SIDE_W;
	localparam int CELLS_TOTAL = MAX_SIDE * MAX_SIDE;

	// Field and register widths
	localparam int MODE_W    = 2;
	localparam int POS_W     = 10;
	localparam int RAD_W     = 6;
	localparam int GW_W      = 9;
	localparam int FILL_W    = 7;
	localparam int CNT_W     = 17;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 9;

	// Sweep arithmetic widths
	localparam int RE_W    = $clog2(MAX_RADIUS + 1);
	localparam int OFF_W   = RE_W + 1;
	localparam int SQ_W    = 2 * RE_W;
	localparam int SUM_W   = SQ_W + 1;
	localparam int COORD_W = POS_W + 1;

	localparam int FILL_MAX = 100;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_STAMP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FILL   = 2'd3;

	// Point test result from the shared unit
	typedef struct packed {
		logic              in_disc;
		logic              in_grid;
		logic [ADDR_W-1:0] addr;
	} pt_res_t;

endpackage

>>> rtl/cdgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cdgs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/cdgs_point.sv
// Shared point unit: disc and grid test, cell address, square step for the sweep.
module cdgs_point import cdgs_pkg::*; (
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [OFF_W-1:0] dx,
	input  logic signed [OFF_W-1:0] dy,
	input  logic [SQ_W-1:0]         dx2,
	input  logic [SQ_W-1:0]         dy2,
	input  logic [SQ_W-1:0]         r2,
	input  logic [GW_W-1:0]         eff_w,
	input  logic [GW_W-1:0]         eff_h,
	input  logic                    row_step,
	output pt_res_t                 pt,
	output logic [SQ_W-1:0]         sq_next
);

	logic signed [COORD_W-1:0] cx;
	logic signed [COORD_W-1:0] cy;
	logic signed [OFF_W-1:0]   d_sel;
	logic [SQ_W-1:0]           sq_sel;
	logic signed [SQ_W+1:0]    sq_sum;

	// Cell coordinates
	assign cx = COORD_W'(pos_x) + COORD_W'(dx);
	assign cy = COORD_W'(pos_y) + COORD_W'(dy);

	// Disc and grid membership
	assign pt.in_disc = (SUM_W'(dx2) + SUM_W'(dy2)) < SUM_W'(r2);
	assign pt.in_grid = !cx[COORD_W-1] && !cy[COORD_W-1]
		&& (cx[COORD_W-2:0] < (COORD_W-1)'(eff_w))
		&& (cy[COORD_W-2:0] < (COORD_W-1)'(eff_h));
	assign pt.addr = {cy[SIDE_W-1:0], cx[SIDE_W-1:0]};

	// (d+1)^2 = d^2 + 2d + 1 on the axis that steps
	assign d_sel  = row_step ? dy : dx;
	assign sq_sel = row_step ? dy2 : dx2;
	assign sq_sum = $signed({2'b00, sq_sel}) + ((SQ_W+2)'(d_sel) <<< 1) + (SQ_W+2)'(1);
	assign sq_next = sq_sum[SQ_W-1:0];

endmodule

>>> rtl/coverage_disc_grid_stamp.sv
// Top level: coverage grid store, sweep sequencer, config registers and result register.
//
// Coverage disc grid stamp. Holds a MAX_SIDE x MAX_SIDE grid of 7-bit cells in one RAM,
// one cell written per clock. After reset the block runs a clearing pass over all
// CELLS_TOTAL (65536) cells with in_stall high; config writes are taken during it. One
// item at a time: a stamp sweeps every offset of the 2r x 2r square (r the saturated
// radius; no sweep when r is zero) through one point unit and one RAM write port; a clear
// writes all 65536 cells, one cell per cycle; a read goes through the registered RAM read
// (skipped when outside the grid); an unused mode goes straight to the finish state. The
// result sits in an output register, so the next item is taken while it waits.
module coverage_disc_grid_stamp import cdgs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [MODE_W-1:0]       mode,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [FILL_W-1:0]       cell_value,
	output logic [CNT_W-1:0]        cells_written,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_PREP  = 3'd2;
	localparam logic [2:0] ST_STAMP = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_RDATA = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0] state_q;

	// Config registers
	logic [RAD_W-1:0]  radius_q;
	logic [GW_W-1:0]   width_q;
	logic [GW_W-1:0]   height_q;
	logic [FILL_W-1:0] fill_cfg_q;

	// Per-item working registers
	logic signed [POS_W-1:0] px_q;
	logic signed [POS_W-1:0] py_q;
	logic [RE_W-1:0]         r_q;
	logic [SQ_W-1:0]         r2_q;
	logic signed [OFF_W-1:0] dx_q;
	logic signed [OFF_W-1:0] dy_q;
	logic [SQ_W-1:0]         dx2_q;
	logic [SQ_W-1:0]         dy2_q;
	logic [FILL_W-1:0]       fill_q;
	logic [GW_W-1:0]         eff_w_q;
	logic [GW_W-1:0]         eff_h_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [FILL_W-1:0]       val_q;
	logic [ADDR_W-1:0]       clr_addr_q;
	logic                    clr_item_q;

	// Output register
	logic              out_valid_q;
	logic [FILL_W-1:0] cell_value_q;
	logic [CNT_W-1:0]  cells_written_q;

	logic              accept;
	logic              fin_load;
	logic [RE_W-1:0]   r_eff;
	logic [FILL_W-1:0] fill_eff;
	logic [GW_W-1:0]   w_eff;
	logic [GW_W-1:0]   h_eff;
	logic [OFF_W-1:0]  r_m1;
	logic [OFF_W-1:0]  r_neg;
	logic              last_x;
	logic              last_y;
	logic              stamp_hit;
	logic              clr_last;
	pt_res_t           pt;
	logic [SQ_W-1:0]   sq_next;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [FILL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [FILL_W-1:0] ram_rdata;

	assign in_stall      = (state_q != ST_IDLE);
	assign accept        = in_valid && !in_stall;
	assign fin_load      = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	assign out_valid     = out_valid_q;
	assign cell_value    = cell_value_q;
	assign cells_written = cells_written_q;

	// Saturated settings, latched per item
	assign r_eff    = (int'(radius_q) > MAX_RADIUS) ? RE_W'(MAX_RADIUS) : RE_W'(radius_q);
	assign fill_eff = (int'(fill_cfg_q) > FILL_MAX) ? FILL_W'(FILL_MAX) : fill_cfg_q;
	assign w_eff    = (int'(width_q) > MAX_SIDE) ? GW_W'(MAX_SIDE) : width_q;
	assign h_eff    = (int'(height_q) > MAX_SIDE) ? GW_W'(MAX_SIDE) : height_q;

	// Sweep bounds
	assign r_m1      = OFF_W'(r_q) - OFF_W'(1);
	assign r_neg     = OFF_W'(0) - OFF_W'(r_q);
	assign last_x    = (dx_q == r_m1);
	assign last_y    = (dy_q == r_m1);
	assign stamp_hit = pt.in_disc && pt.in_grid;
	assign clr_last  = (clr_addr_q == ADDR_W'(CELLS_TOTAL - 1));

	cdgs_point u_point (
		.pos_x    (px_q),
		.pos_y    (py_q),
		.dx       (dx_q),
		.dy       (dy_q),
		.dx2      (dx2_q),
		.dy2      (dy2_q),
		.r2       (r2_q),
		.eff_w    (eff_w_q),
		.eff_h    (eff_h_q),
		.row_step (last_x),
		.pt       (pt),
		.sq_next  (sq_next)
	);

	// Grid store ports
	assign ram_we    = (state_q == ST_CLEAR) || ((state_q == ST_STAMP) && stamp_hit);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : pt.addr;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : fill_q;
	assign ram_re    = (state_q == ST_READ) && pt.in_grid;

	cdgs_ram #(
		.WIDTH (FILL_W),
		.DEPTH (CELLS_TOTAL)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (pt.addr),
		.rdata (ram_rdata)
	);

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q   <= RAD_W'(12);
			width_q    <= GW_W'(200);
			height_q   <= GW_W'(200);
			fill_cfg_q <= FILL_W'(50);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIUS: radius_q   <= cfg_data[RAD_W-1:0];
				REG_WIDTH:  width_q    <= cfg_data[GW_W-1:0];
				REG_HEIGHT: height_q   <= cfg_data[GW_W-1:0];
				REG_FILL:   fill_cfg_q <= cfg_data[FILL_W-1:0];
				default:    ;
			endcase
		end
	end

	// Sequencer control; reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			clr_item_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (mode)
							MODE_STAMP: state_q <= ST_PREP;
							MODE_CLEAR: begin
								state_q    <= ST_CLEAR;
								clr_addr_q <= '0;
								clr_item_q <= 1'b1;
							end
							MODE_READ:  state_q <= ST_READ;
							default:    state_q <= ST_FIN;
						endcase
					end
				end
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_last) begin
						state_q <= clr_item_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_PREP: begin
					state_q <= (r_q == '0) ? ST_FIN : ST_STAMP;
				end
				ST_STAMP: begin
					if (last_x && last_y) begin
						state_q <= ST_FIN;
					end
				end
				ST_READ: begin
					state_q <= pt.in_grid ? ST_RDATA : ST_FIN;
				end
				ST_RDATA: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item payload and sweep registers
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q    <= pos_x;
			py_q    <= pos_y;
			r_q     <= r_eff;
			r2_q    <= SQ_W'(r_eff) * SQ_W'(r_eff);
			fill_q  <= fill_eff;
			eff_w_q <= w_eff;
			eff_h_q <= h_eff;
			val_q   <= '0;
			dx_q    <= '0;
			dy_q    <= '0;
			cnt_q   <= (mode == MODE_CLEAR) ? CNT_W'(CELLS_TOTAL) : '0;
		end

		// Start of sweep: top-left corner of the square
		if (state_q == ST_PREP) begin
			dx_q  <= $signed(r_neg);
			dy_q  <= $signed(r_neg);
			dx2_q <= r2_q;
			dy2_q <= r2_q;
		end

		// One offset per cycle, row by row
		if (state_q == ST_STAMP) begin
			if (stamp_hit) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (last_x) begin
				dx_q  <= $signed(r_neg);
				dx2_q <= r2_q;
				dy_q  <= dy_q + OFF_W'(1);
				dy2_q <= sq_next;
			end else begin
				dx_q  <= dx_q + OFF_W'(1);
				dx2_q <= sq_next;
			end
		end

		if (state_q == ST_RDATA) begin
			val_q <= ram_rdata;
		end

		if (fin_load) begin
			cell_value_q    <= val_q;
			cells_written_q <= cnt_q;
		end
	end

endmodule

>>> rtl/cdgs_check.sv
// Port-level checks of the coverage disc grid stamp, bound to the top level.
module cdgs_check import cdgs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [FILL_W-1:0] cell_value,
	input logic [CNT_W-1:0]  cells_written
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cell_value) && $stable(cells_written))
		else $error("result beat changed while stalled");

	// An accepted item keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepting a beat");

	// A read value never comes with a write count
	a_read_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (cell_value != '0) |-> (cells_written == '0))
		else $error("nonzero cell value with nonzero write count");

	// A new result appears only after the block was busy
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised without a busy cycle");

endmodule

bind coverage_disc_grid_stamp cdgs_check u_cdgs_check (.*);
